FILE: hw/rtl/sled_pkg.sv
`timescale 1ns / 1ps

package sled_pkg;

	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 11;
	localparam int unsigned LEN_W = 11;

	localparam logic [CFG_IDX_W-1:0] CFG_MIN_PRINTABLE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_PRINTABLE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH    = 2'd2;

	localparam logic [7:0]       RST_MIN_PRINTABLE = 8'd32;
	localparam logic [7:0]       RST_MAX_PRINTABLE = 8'd126;
	localparam logic [LEN_W-1:0] RST_MAX_LENGTH    = 11'd255;

	localparam logic [3:0] ST_PENDING    = 4'd0;
	localparam logic [3:0] ST_DONE       = 4'd1;
	localparam logic [3:0] ST_NO_OPEN    = 4'd2;
	localparam logic [3:0] ST_TOO_LONG   = 4'd3;
	localparam logic [3:0] ST_BAD_ESC    = 4'd4;
	localparam logic [3:0] ST_BAD_HEX    = 4'd5;
	localparam logic [3:0] ST_INNER_Q    = 4'd6;
	localparam logic [3:0] ST_RANGE      = 4'd7;
	localparam logic [3:0] ST_NOT_CLOSED = 4'd8;
	localparam logic [3:0] ST_DISCARD    = 4'd9;

	typedef enum logic [2:0] {
		PH_OPEN    = 3'd0,
		PH_BODY    = 3'd1,
		PH_ESC     = 3'd2,
		PH_ZERO    = 3'd3,
		PH_HEXHI   = 3'd4,
		PH_HEXLO   = 3'd5,
		PH_DISCARD = 3'd6
	} phase_t;

	typedef struct packed {
		logic [7:0]       min_printable;
		logic [7:0]       max_printable;
		logic [LEN_W-1:0] max_length;
	} cfg_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_item_t;

	typedef struct packed {
		logic       data_valid;
		logic [7:0] out_byte;
		logic [3:0] status;
	} out_item_t;

endpackage

FILE: hw/rtl/sled_step.sv
`timescale 1ns / 1ps

module sled_step (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  sled_pkg::in_item_t item,
	input  sled_pkg::cfg_t     cfg,
	output sled_pkg::out_item_t result
);
	import sled_pkg::*;

	localparam logic [7:0] CH_QUOTE     = 8'h22;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_ZERO      = 8'h30;
	localparam logic [7:0] CH_X         = 8'h78;

	function automatic logic [4:0] hex_digit(input logic [7:0] b);
		logic [4:0] r;
		r = 5'd0;
		if (b >= 8'h30 && b <= 8'h39) begin
			r = {1'b1, 4'(b - 8'h30)};
		end else if (b >= 8'h61 && b <= 8'h66) begin
			r = {1'b1, 4'(b - 8'h57)};
		end else if (b >= 8'h41 && b <= 8'h46) begin
			r = {1'b1, 4'(b - 8'h37)};
		end
		return r;
	endfunction

	function automatic logic [8:0] simple_escape(input logic [7:0] b);
		logic [8:0] r;
		r = 9'd0;
		case (b)
			8'h61: r = {1'b1, 8'h07};
			8'h62: r = {1'b1, 8'h08};
			8'h65: r = {1'b1, 8'h1B};
			8'h66: r = {1'b1, 8'h0C};
			8'h6E: r = {1'b1, 8'h0A};
			8'h72: r = {1'b1, 8'h0D};
			8'h74: r = {1'b1, 8'h09};
			8'h76: r = {1'b1, 8'h0B};
			8'h5C: r = {1'b1, 8'h5C};
			8'h27: r = {1'b1, 8'h27};
			8'h22: r = {1'b1, 8'h22};
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	phase_t           phase_q, phase_n;
	logic [3:0]       hex_hi_q, hex_hi_n;
	logic [LEN_W-1:0] count_q, count_n;

	logic [4:0] hex_r;
	logic [8:0] esc_r;
	logic       ch_valid;
	logic [7:0] ch;
	logic [3:0] status;

	always_comb begin
		hex_r = hex_digit(item.in_byte);
		esc_r = simple_escape(item.in_byte);
		ch_valid = 1'b0;
		ch = 8'd0;
		status = ST_PENDING;
		phase_n = phase_q;
		hex_hi_n = hex_hi_q;
		count_n = count_q;
		case (phase_q)
			PH_OPEN: begin
				if (item.in_byte == CH_QUOTE) phase_n = PH_BODY;
				else status = ST_NO_OPEN;
			end
			PH_BODY: begin
				if (item.in_byte == CH_QUOTE) begin
					status = item.in_last ? ST_DONE : ST_INNER_Q;
				end else if (count_q >= cfg.max_length) begin
					status = ST_TOO_LONG;
				end else if (item.in_byte == CH_BACKSLASH) begin
					phase_n = PH_ESC;
				end else if (item.in_byte < cfg.min_printable ||
						item.in_byte > cfg.max_printable) begin
					status = ST_RANGE;
				end else begin
					ch_valid = 1'b1;
					ch = item.in_byte;
				end
			end
			PH_ESC: begin
				if (esc_r[8]) begin
					ch_valid = 1'b1;
					ch = esc_r[7:0];
					phase_n = PH_BODY;
				end else if (item.in_byte == CH_ZERO) begin
					phase_n = PH_ZERO;
				end else begin
					status = ST_BAD_ESC;
				end
			end
			PH_ZERO: begin
				if (item.in_byte == CH_X) phase_n = PH_HEXHI;
				else status = ST_BAD_ESC;
			end
			PH_HEXHI: begin
				if (hex_r[4]) begin
					hex_hi_n = hex_r[3:0];
					phase_n = PH_HEXLO;
				end else begin
					status = ST_BAD_HEX;
				end
			end
			PH_HEXLO: begin
				if (hex_r[4]) begin
					ch_valid = 1'b1;
					ch = {hex_hi_q, hex_r[3:0]};
					phase_n = PH_BODY;
				end else begin
					status = ST_BAD_HEX;
				end
			end
			default: begin
				status = ST_DISCARD;
			end
		endcase

		if (ch_valid) count_n = count_q + LEN_W'(1);
		if (item.in_last && status == ST_PENDING) status = ST_NOT_CLOSED;
		if (status != ST_PENDING) begin
			ch_valid = 1'b0;
			ch = 8'd0;
		end
		if (item.in_last) begin
			phase_n = PH_OPEN;
			hex_hi_n = 4'd0;
			count_n = '0;
		end else if (status != ST_PENDING) begin
			phase_n = PH_DISCARD;
		end

		result.data_valid = ch_valid;
		result.out_byte = ch;
		result.status = status;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_OPEN;
			hex_hi_q <= 4'd0;
			count_q <= '0;
		end else if (fire) begin
			phase_q <= phase_n;
			hex_hi_q <= hex_hi_n;
			count_q <= count_n;
		end
	end

	a_error_discards: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !item.in_last && result.status != ST_PENDING |=> phase_q == PH_DISCARD)
		else $error("error without discard");

	a_last_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.in_last |=> phase_q == PH_OPEN && count_q == '0 && hex_hi_q == 4'd0)
		else $error("literal end did not restart");

	a_char_only_pending: assert property (@(posedge clk) disable iff (!arst_n)
		fire && result.data_valid |-> result.status == ST_PENDING && !item.in_last)
		else $error("character with final status");

	a_count_tracks_char: assert property (@(posedge clk) disable iff (!arst_n)
		fire && result.data_valid |=> count_q == $past(count_q) + LEN_W'(1))
		else $error("count not advanced");

endmodule

FILE: hw/rtl/sled_out_reg.sv
`timescale 1ns / 1ps

module sled_out_reg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  sled_pkg::out_item_t d,
	output logic                can_load,
	output logic                out_valid,
	input  logic                out_stall,
	output sled_pkg::out_item_t out_item
);
	import sled_pkg::*;

	logic      valid_q;
	out_item_t item_q;

	assign can_load = !valid_q || !out_stall;
	assign out_valid = valid_q;
	assign out_item = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_load) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (can_load && load) begin
			item_q <= d;
		end
	end

	a_load_only_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> can_load)
		else $error("result loaded into a full register");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> valid_q && item_q == $past(d))
		else $error("loaded result not presented");

	a_drain_empties: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !out_stall && !load |=> !valid_q)
		else $error("taken result repeated");

endmodule

FILE: hw/rtl/string_literal_escape_decoder.sv
`timescale 1ns / 1ps
// A result is presented after its item is accepted: the item waits in the input
// register and is then held in the result register. Throughput is one item per cycle
// unless the output stalls; the decode step updates its state as each item advances.
// Reset is asynchronous and active low; it empties both registers, returns the decoder
// to expecting an opening quote, and restores the configuration defaults.
module string_literal_escape_decoder (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  sled_pkg::in_item_t     in_item,
	output logic                   out_valid,
	input  logic                   out_stall,
	output sled_pkg::out_item_t    out_item,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [sled_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sled_pkg::CFG_DATA_W-1:0] cfg_data
);
	import sled_pkg::*;

	cfg_t      cfg_q;
	logic      valid_s1;
	in_item_t  item_s1;
	logic      adv_s1;
	logic      can_load;
	out_item_t result;

	assign cfg_ready = 1'b1;
	assign adv_s1 = valid_s1 && can_load;
	assign in_stall = valid_s1 && !can_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_printable <= RST_MIN_PRINTABLE;
			cfg_q.max_printable <= RST_MAX_PRINTABLE;
			cfg_q.max_length <= RST_MAX_LENGTH;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_MIN_PRINTABLE: cfg_q.min_printable <= cfg_data[7:0];
				CFG_MAX_PRINTABLE: cfg_q.max_printable <= cfg_data[7:0];
				CFG_MAX_LENGTH: cfg_q.max_length <= cfg_data[LEN_W-1:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_item;
		end
	end

	sled_step u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (adv_s1),
		.item   (item_s1),
		.cfg    (cfg_q),
		.result (result)
	);

	sled_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (adv_s1),
		.d         (result),
		.can_load  (can_load),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

	a_held_item_stays: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s1 |=> valid_s1 && $stable(item_s1))
		else $error("waiting item lost");

	a_advance_presents: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> out_valid)
		else $error("decoded item not presented");

	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> valid_s1 && item_s1 == $past(in_item))
		else $error("accepted item not captured");

endmodule
